[rtl/core/clt_pkg.sv]
package clt_pkg;

    localparam int OFFSET_BITS_DEF    = 16;
    localparam int MAX_ARGS_LIMIT_DEF = 64;

    localparam int CFG_W  = 7;
    localparam int OUT_W  = 16;
    localparam int LINE_W = 16;
    localparam int NUM_W  = 7;
    localparam int BYTE_W = 8;

    localparam logic [CFG_W-1:0] MAX_ARGS_RESET = 7'd64;

    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        EV_ARG       = 2'd0,
        EV_LINE      = 2'd1,
        EV_QUOTE_ERR = 2'd2,
        EV_MAX_ERR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_SKIP  = 2'd0,
        MODE_WORD  = 2'd1,
        MODE_QUOTE = 2'd2,
        MODE_STOP  = 2'd3
    } t_mode;

    typedef struct packed {
        t_kind              kind;
        logic [OUT_W-1:0]   offset;
        logic [OUT_W-1:0]   length;
        logic [NUM_W-1:0]   num;
        logic [LINE_W-1:0]  line;
        logic               last;
    } t_event;

    // Results of one input item: how many, and up to two of them in order.
    typedef struct packed {
        logic [1:0] count;
        t_event     ev1;
        t_event     ev0;
    } t_scan_out;

    function automatic t_event make_event(t_kind kind, logic [OUT_W-1:0] offset,
                                          logic [OUT_W-1:0] length,
                                          logic [NUM_W-1:0] num,
                                          logic [LINE_W-1:0] line);
        t_event e;
        e.kind   = kind;
        e.offset = offset;
        e.length = length;
        e.num    = num;
        e.line   = line;
        e.last   = 1'b0;
        return e;
    endfunction

endpackage

[rtl/core/command_line_tokenizer_core.sv]
// Each accepted byte is held in the scanner's input register; its results are then
// written into the result queue, whose head is offered on the output.
// Throughput: one byte per cycle while the four-entry result queue has room; a byte
// yields zero to two results, and the queue gives one result per cycle when taken.
// Reset (synchronous, active low) returns to line 1, offset 0, skipping whitespace,
// with max_args at 64 and the result queue empty.
module command_line_tokenizer_core #(
    parameter int OFFSET_BITS    = clt_pkg::OFFSET_BITS_DEF,
    parameter int MAX_ARGS_LIMIT = clt_pkg::MAX_ARGS_LIMIT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [7:0]                 i_s_axis_tdata,   // [7:0] char_byte
    input  logic                       i_s_axis_tlast,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // [15:0] token_offset, [31:16] token_length, [38:32] arg_number,
    // [54:39] line_no, [55] zero
    output logic [55:0]                o_m_axis_tdata,
    output logic [1:0]                 o_m_axis_tuser,   // [1:0] event_kind
    output logic                       o_m_axis_tlast,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [clt_pkg::CFG_W-1:0]  i_cfg_data
);
    import clt_pkg::*;

    t_scan_out  scan_res;
    t_event     r_queue [4];
    logic [1:0] r_wptr, r_rptr;
    logic [2:0] r_count, n_count;
    logic       pop;
    logic       accept;
    t_event     head;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_s_axis_tvalid && o_s_axis_tready;

    clt_scan #(
        .OFFSET_BITS    (OFFSET_BITS),
        .MAX_ARGS_LIMIT (MAX_ARGS_LIMIT)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_s_axis_tdata),
        .i_final    (i_s_axis_tlast),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_res      (scan_res)
    );

    assign pop     = o_m_axis_tvalid && i_m_axis_tready;
    assign n_count = r_count - {2'b00, pop} + {1'b0, scan_res.count};

    // The byte accepted now writes at most two results next cycle.
    assign o_s_axis_tready = n_count <= 3'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + scan_res.count;
            r_rptr  <= r_rptr + {1'b0, pop};
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_res.count != 2'd0) begin
            r_queue[r_wptr] <= scan_res.ev0;
        end
        if (scan_res.count == 2'd2) begin
            r_queue[r_wptr + 2'd1] <= scan_res.ev1;
        end
    end

    assign head            = r_queue[r_rptr];
    assign o_m_axis_tvalid = r_count != 3'd0;
    assign o_m_axis_tdata  = {1'b0, head.line, head.num, head.length, head.offset};
    assign o_m_axis_tuser  = head.kind;
    assign o_m_axis_tlast  = head.last;

endmodule

[rtl/core/clt_scan.sv]
module clt_scan #(
    parameter int OFFSET_BITS    = clt_pkg::OFFSET_BITS_DEF,
    parameter int MAX_ARGS_LIMIT = clt_pkg::MAX_ARGS_LIMIT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [clt_pkg::BYTE_W-1:0]  i_byte,
    input  logic                        i_final,
    input  logic                        i_cfg_we,
    input  logic [clt_pkg::CFG_W-1:0]   i_cfg_data,
    output clt_pkg::t_scan_out          o_res
);
    import clt_pkg::*;

    localparam int AW = $clog2(MAX_ARGS_LIMIT + 1);

    logic                   r_in_valid;
    logic [BYTE_W-1:0]      r_in_byte;
    logic                   r_in_final;

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_begin, n_begin;
    logic [AW-1:0]          r_args, n_args;
    logic [LINE_W-1:0]      r_line, n_line;
    logic [CFG_W-1:0]       r_max_args;

    logic [OFFSET_BITS-1:0] pos1;
    logic [LINE_W-1:0]      line1;
    logic [31:0]            limit;
    logic                   over_limit;

    t_event                 evs [2];
    logic [1:0]             cnt;
    logic                   is_ws, is_nl, is_quote, is_cr;
    logic                   close_req, nl_post, q_post;
    logic [OFFSET_BITS-1:0] close_end;
    logic [LINE_W-1:0]      close_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_SKIP;
            r_pos      <= '0;
            r_begin    <= '0;
            r_args     <= '0;
            r_line     <= LINE_W'(1);
            r_max_args <= MAX_ARGS_RESET;
        end else begin
            r_in_valid <= i_accept;
            if (r_in_valid) begin
                r_mode  <= n_mode;
                r_pos   <= n_pos;
                r_begin <= n_begin;
                r_args  <= n_args;
                r_line  <= n_line;
            end
            if (i_cfg_we) begin
                r_max_args <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_in_byte  <= i_byte;
            r_in_final <= i_final;
        end
    end

    assign pos1  = (r_pos == '1) ? r_pos : r_pos + OFFSET_BITS'(1);
    assign line1 = (r_line == '1) ? r_line : r_line + LINE_W'(1);
    assign limit = (32'(r_max_args) < 32'(MAX_ARGS_LIMIT)) ? 32'(r_max_args)
                                                           : 32'(MAX_ARGS_LIMIT);
    assign over_limit = 32'(r_args) >= limit;

    assign is_nl    = r_in_byte == CH_LF;
    assign is_cr    = r_in_byte == CH_CR;
    assign is_quote = r_in_byte == CH_QUOTE;
    assign is_ws    = (r_in_byte == CH_SPACE) || (r_in_byte == CH_TAB) || is_cr;

    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_begin   = r_begin;
        n_args    = r_args;
        n_line    = r_line;
        evs[0]    = '0;
        evs[1]    = '0;
        cnt       = 2'd0;
        close_req = 1'b0;
        close_end = r_pos;
        close_err = r_line;
        nl_post   = 1'b0;
        q_post    = 1'b0;

        case (r_mode)
            MODE_SKIP: begin
                if (is_nl) begin
                    if (n_args != '0) begin
                        evs[cnt[0]] = make_event(EV_LINE, '0, '0,
                                                 NUM_W'(32'(n_args)), n_line);
                        cnt = cnt + 2'd1;
                    end
                    n_line = line1;
                    n_args = '0;
                end else if (is_quote) begin
                    n_mode  = MODE_QUOTE;
                    n_begin = pos1;
                end else if (!is_ws) begin
                    n_mode  = MODE_WORD;
                    n_begin = r_pos;
                    // A one-byte word on the final byte closes right away.
                    if (r_in_final) begin
                        close_req = 1'b1;
                        close_end = pos1;
                    end
                end
            end
            MODE_WORD: begin
                if (is_nl) begin
                    close_req = 1'b1;
                    close_err = line1;
                    nl_post   = 1'b1;
                end else if (is_ws || is_quote) begin
                    close_req = 1'b1;
                    q_post    = is_quote;
                end else if (r_in_final) begin
                    close_req = 1'b1;
                    close_end = pos1;
                end
            end
            MODE_QUOTE: begin
                if (is_quote) begin
                    close_req = 1'b1;
                end else if (is_cr || is_nl) begin
                    evs[cnt[0]] = make_event(EV_QUOTE_ERR,
                                             OUT_W'(32'(n_begin)), '0, '0, n_line);
                    cnt    = cnt + 2'd1;
                    n_mode = MODE_STOP;
                end
            end
            default: begin
            end
        endcase

        if (close_req) begin
            if (over_limit) begin
                evs[cnt[0]] = make_event(EV_MAX_ERR, OUT_W'(32'(n_begin)), '0, '0,
                                         close_err);
                n_mode = MODE_STOP;
            end else begin
                evs[cnt[0]] = make_event(EV_ARG, OUT_W'(32'(n_begin)),
                                         OUT_W'(32'(close_end - n_begin)),
                                         NUM_W'(32'(n_args)), n_line);
                n_args = n_args + AW'(1);
                n_mode = MODE_SKIP;
            end
            cnt = cnt + 2'd1;
        end

        if (nl_post) begin
            if (n_mode == MODE_SKIP) begin
                evs[cnt[0]] = make_event(EV_LINE, '0, '0, NUM_W'(32'(n_args)), n_line);
                cnt = cnt + 2'd1;
            end
            n_line = line1;
            n_args = '0;
        end

        // A quote that ends a word also opens a quoted argument unless the limit was hit.
        if (q_post && n_mode == MODE_SKIP) begin
            n_mode  = MODE_QUOTE;
            n_begin = pos1;
        end

        if (r_in_final) begin
            if (n_mode == MODE_QUOTE) begin
                evs[cnt[0]] = make_event(EV_QUOTE_ERR, OUT_W'(32'(n_begin)), '0, '0,
                                         n_line);
                cnt    = cnt + 2'd1;
                n_mode = MODE_STOP;
            end
            if (n_mode == MODE_SKIP && n_args != '0) begin
                evs[cnt[0]] = make_event(EV_LINE, '0, '0, NUM_W'(32'(n_args)), n_line);
                cnt = cnt + 2'd1;
            end
            n_mode  = MODE_SKIP;
            n_pos   = '0;
            n_begin = '0;
            n_args  = '0;
            n_line  = LINE_W'(1);
        end else begin
            n_pos = pos1;
        end

        if (cnt == 2'd1) begin
            evs[0].last = 1'b1;
        end
        if (cnt == 2'd2) begin
            evs[1].last = 1'b1;
        end

        o_res.count = r_in_valid ? cnt : 2'd0;
        o_res.ev0   = evs[0];
        o_res.ev1   = evs[1];
    end

endmodule
